// ===== design/vtm_pkg.sv =====
// Shared types and constants of the virtual timer multiplexer.
package vtm_pkg;

  // Field and bus widths
  localparam int TIMER_ID_W   = 4;
  localparam int TIME_W       = 64;
  localparam int WORD_W       = 32;
  localparam int BACKOFF_W    = 16;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;

  // Table size limits
  localparam int MAX_TABLE        = 1 << TIMER_ID_W;
  localparam int NUM_TIMERS_DEF   = 16;

  // Request codes
  localparam logic [1:0] REQ_SET    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  // Register map (word index)
  localparam logic REG_BACKOFF = 1'b0;

  // Reset value of backoff_ticks
  localparam logic [BACKOFF_W-1:0] BACKOFF_RESET = 16'd30;

  // Request to the shared adder/comparator
  typedef struct packed {
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    logic              sub;
  } alu_req_t;

  // Response of the shared adder/comparator
  typedef struct packed {
    logic [TIME_W-1:0] sum;
    logic              lt;
    logic              eq;
  } alu_rsp_t;

endpackage

// ===== design/vtm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module vtm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/vtm_alu.sv =====
// Shared 64-bit adder/subtractor with unsigned less-than and equality flags.
module vtm_alu (
  input  vtm_pkg::alu_req_t req,
  output vtm_pkg::alu_rsp_t rsp
);

  logic [vtm_pkg::TIME_W:0]   total;
  logic [vtm_pkg::TIME_W-1:0] b_op;

  // Invert b and add one for subtraction
  assign b_op  = req.sub ? ~req.b : req.b;
  assign total = {1'b0, req.a} + {1'b0, b_op} + {{vtm_pkg::TIME_W{1'b0}}, req.sub};

  // No carry out of a subtraction means a borrow: a < b
  assign rsp.sum = total[vtm_pkg::TIME_W-1:0];
  assign rsp.lt  = req.sub & ~total[vtm_pkg::TIME_W];
  assign rsp.eq  = (total[vtm_pkg::TIME_W-1:0] == '0);

endmodule

// ===== design/virtual_timer_multiplexer_unit.sv =====
// Top level of the virtual timer multiplexer: sequencer, timer table and register port.
//
// Usage: requests enter on the in_ channel (valid/ready); each request yields one or
// more transactions on the out_ channel, the final one flagged by out_last. A set
// re-arms a timer at now plus the 64-bit offset, or reports it at once when the
// offset is below backoff_ticks. A remove cancels a timer. A tick advances time by
// one and reports every due timer in deadline order, lowest id first on ties.
// Deadlines live in a RAM; active flags live in flip-flops.
// A set passes through the set state to the emit state; a remove or an unused code goes
// straight to emit, which loads the result register. A tick advances time, then makes
// one full pass of the shared comparator over the deadline RAM per fired timer plus a
// final pass that finds none, one entry per cycle, behind its registered read.
// in_ready is high only while the sequencer is idle; it goes idle as soon as the
// final result is loaded, so the next request may be taken while that result waits.
// A stalled receiver holds the output register and the sequencer waits for it.
// Reset (synchronous, active low) clears time, all active flags, the output valid flag
// and sets backoff_ticks to 30; the deadline RAM is not cleared. The APB port is
// always ready; backoff_ticks sits at byte address 0.
module virtual_timer_multiplexer_unit #(
  parameter int NUM_TIMERS = vtm_pkg::NUM_TIMERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_req_type,
  input  logic [vtm_pkg::TIMER_ID_W-1:0]    in_timer_id,
  input  logic [vtm_pkg::WORD_W-1:0]        in_offset_low,
  input  logic [vtm_pkg::WORD_W-1:0]        in_offset_high,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_fired_valid,
  output logic [vtm_pkg::TIMER_ID_W-1:0]    out_fired_id,
  output logic                              out_last,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vtm_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [vtm_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [vtm_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int TABLE_DEPTH = (NUM_TIMERS < vtm_pkg::MAX_TABLE) ? NUM_TIMERS
                                                                  : vtm_pkg::MAX_TABLE;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int TW    = vtm_pkg::TIME_W;
  localparam int IDW   = vtm_pkg::TIMER_ID_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET,
    ST_TICK,
    ST_SCAN,
    ST_END,
    ST_EMIT
  } state_t;

  // Registers
  state_t                        state_r, state_nxt;
  logic [TW-1:0]                 now_r, now_nxt;
  logic [TABLE_DEPTH-1:0]        active_r, active_nxt;
  logic [vtm_pkg::BACKOFF_W-1:0] backoff_r;
  logic [IDX_W-1:0]              id_r, id_nxt;
  logic [vtm_pkg::WORD_W-1:0]    off_lo_r, off_lo_nxt;
  logic [vtm_pkg::WORD_W-1:0]    off_hi_r, off_hi_nxt;
  logic [CNT_W-1:0]              scan_cnt_r, scan_cnt_nxt;
  logic                          cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]              cmp_idx_r, cmp_idx_nxt;
  logic [TW-1:0]                 best_r, best_nxt;
  logic [IDX_W-1:0]              best_id_r, best_id_nxt;
  logic                          found_r, found_nxt;
  logic                          pend_vld_r, pend_vld_nxt;
  logic [IDX_W-1:0]              pend_id_r, pend_id_nxt;
  logic                          res_fired_r, res_fired_nxt;
  logic [IDW-1:0]                res_id_r, res_id_nxt;
  logic                          res_last_r, res_last_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_fired_r, out_fired_nxt;
  logic [IDW-1:0]                out_id_r, out_id_nxt;
  logic                          out_last_r, out_last_nxt;

  // Shared unit and RAM signals
  vtm_pkg::alu_req_t alu_req;
  vtm_pkg::alu_rsp_t alu_rsp;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [TW-1:0]     ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [TW-1:0]     ram_rdata;

  logic              id_ok;
  logic              out_free;
  logic              cfg_wr;

  vtm_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  vtm_ram #(
    .WIDTH (TW),
    .DEPTH (TABLE_DEPTH)
  ) u_deadline_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Register port: always ready, one register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == vtm_pkg::REG_BACKOFF);
  assign prdata = (paddr[2] == vtm_pkg::REG_BACKOFF)
                ? {{(vtm_pkg::APB_DATA_W - vtm_pkg::BACKOFF_W){1'b0}}, backoff_r}
                : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backoff_r <= vtm_pkg::BACKOFF_RESET;
    end else if (cfg_wr) begin
      backoff_r <= pwdata[vtm_pkg::BACKOFF_W-1:0];
    end
  end

  // Handshake outputs
  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_fired_valid = out_fired_r;
  assign out_fired_id    = out_id_r;
  assign out_last        = out_last_r;
  assign out_free        = ~out_valid_r | out_ready;

  assign id_ok     = ({1'b0, in_timer_id} < (IDW + 1)'(TABLE_DEPTH));
  assign ram_raddr = scan_cnt_r[IDX_W-1:0];

  // Sequencer next-state logic
  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    active_nxt    = active_r;
    id_nxt        = id_r;
    off_lo_nxt    = off_lo_r;
    off_hi_nxt    = off_hi_r;
    scan_cnt_nxt  = scan_cnt_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    best_nxt      = best_r;
    best_id_nxt   = best_id_r;
    found_nxt     = found_r;
    pend_vld_nxt  = pend_vld_r;
    pend_id_nxt   = pend_id_r;
    res_fired_nxt = res_fired_r;
    res_id_nxt    = res_id_r;
    res_last_nxt  = res_last_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_fired_nxt = out_fired_r;
    out_id_nxt    = out_id_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_waddr     = id_r;
    ram_wdata     = alu_rsp.sum;
    alu_req.a     = ram_rdata;
    alu_req.b     = best_r;
    alu_req.sub   = 1'b1;

    case (state_r)
      ST_IDLE: begin
        // Take a request and decode it
        if (in_valid) begin
          id_nxt        = IDX_W'(in_timer_id);
          off_lo_nxt    = in_offset_low;
          off_hi_nxt    = in_offset_high;
          res_fired_nxt = 1'b0;
          res_id_nxt    = '0;
          res_last_nxt  = 1'b1;
          if (in_req_type == vtm_pkg::REQ_SET && id_ok) begin
            active_nxt[IDX_W'(in_timer_id)] = 1'b0;
            state_nxt = ST_SET;
          end else if (in_req_type == vtm_pkg::REQ_REMOVE && id_ok) begin
            active_nxt[IDX_W'(in_timer_id)] = 1'b0;
            state_nxt = ST_EMIT;
          end else if (in_req_type == vtm_pkg::REQ_TICK) begin
            state_nxt = ST_TICK;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end

      ST_SET: begin
        // Deadline = now + offset; short offsets fire at once
        alu_req.a   = now_r;
        alu_req.b   = {off_hi_r, off_lo_r};
        alu_req.sub = 1'b0;
        if (off_hi_r == '0 &&
            off_lo_r < {{(vtm_pkg::WORD_W - vtm_pkg::BACKOFF_W){1'b0}}, backoff_r}) begin
          res_fired_nxt = 1'b1;
          res_id_nxt    = IDW'(id_r);
        end else begin
          ram_we            = 1'b1;
          active_nxt[id_r]  = 1'b1;
        end
        state_nxt = ST_EMIT;
      end

      ST_TICK: begin
        // Advance time and start the first pass
        alu_req.a    = now_r;
        alu_req.b    = {{(TW - 1){1'b0}}, 1'b1};
        alu_req.sub  = 1'b0;
        now_nxt      = alu_rsp.sum;
        best_nxt     = alu_rsp.sum;
        found_nxt    = 1'b0;
        scan_cnt_nxt = '0;
        cmp_vld_nxt  = 1'b0;
        state_nxt    = ST_SCAN;
      end

      ST_SCAN: begin
        // Issue one read per cycle
        if (scan_cnt_r < CNT_W'(TABLE_DEPTH)) begin
          scan_cnt_nxt = CNT_W'(scan_cnt_r + 1'b1);
          cmp_vld_nxt  = 1'b1;
          cmp_idx_nxt  = ram_raddr;
        end else begin
          cmp_vld_nxt  = 1'b0;
        end
        // Keep the earliest due deadline, lowest id on ties
        if (cmp_vld_r && active_r[cmp_idx_r] &&
            (alu_rsp.lt || (alu_rsp.eq && !found_r))) begin
          best_nxt    = ram_rdata;
          best_id_nxt = cmp_idx_r;
          found_nxt   = 1'b1;
        end
        if (scan_cnt_r == CNT_W'(TABLE_DEPTH) && !cmp_vld_r) begin
          state_nxt = ST_END;
        end
      end

      ST_END: begin
        // Retire the pass: hold one fired id back so the final one carries last
        found_nxt = 1'b0;
        if (found_r) begin
          active_nxt[best_id_r] = 1'b0;
          pend_vld_nxt          = 1'b1;
          pend_id_nxt           = best_id_r;
          if (pend_vld_r) begin
            res_fired_nxt = 1'b1;
            res_id_nxt    = IDW'(pend_id_r);
            res_last_nxt  = 1'b0;
            state_nxt     = ST_EMIT;
          end else begin
            best_nxt     = now_r;
            scan_cnt_nxt = '0;
            cmp_vld_nxt  = 1'b0;
            state_nxt    = ST_SCAN;
          end
        end else begin
          pend_vld_nxt  = 1'b0;
          res_fired_nxt = pend_vld_r;
          res_id_nxt    = pend_vld_r ? IDW'(pend_id_r) : '0;
          res_last_nxt  = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end

      ST_EMIT: begin
        // Load the output register once it is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_fired_nxt = res_fired_r;
          out_id_nxt    = res_id_r;
          out_last_nxt  = res_last_r;
          if (res_last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            best_nxt     = now_r;
            found_nxt    = 1'b0;
            scan_cnt_nxt = '0;
            cmp_vld_nxt  = 1'b0;
            state_nxt    = ST_SCAN;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      active_r    <= '0;
      scan_cnt_r  <= '0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      active_r    <= active_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      found_r     <= found_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    id_r        <= id_nxt;
    off_lo_r    <= off_lo_nxt;
    off_hi_r    <= off_hi_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    best_r      <= best_nxt;
    best_id_r   <= best_id_nxt;
    pend_id_r   <= pend_id_nxt;
    res_fired_r <= res_fired_nxt;
    res_id_r    <= res_id_nxt;
    res_last_r  <= res_last_nxt;
    out_fired_r <= out_fired_nxt;
    out_id_r    <= out_id_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Sequencer is busy right after taking a request
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready
  ) else $error("request accepted while sequencer still idle");

  // No held-back fired id survives into idle
  a_no_pending_in_idle: assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_vld_r
  ) else $error("fired timer left pending at idle");

  // The current candidate always refers to an armed timer
  a_best_is_active: assert property (
    @(posedge clk) disable iff (!rst_n)
    found_r |-> active_r[best_id_r]
  ) else $error("candidate timer is not active");

  // A result is only loaded from the emit state
  a_load_from_emit: assert property (
    @(posedge clk) disable iff (!rst_n)
    (!out_valid_r || out_ready) && (state_r != ST_EMIT) |=> !out_valid_r
  ) else $error("output loaded outside emit state");

endmodule

// ===== test/vtm_checker.sv =====
// Checker of the virtual timer multiplexer: predicts fired timers and compares every result.
module vtm_checker
  import vtm_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [1:0]            in_req_type,
  input  logic [TIMER_ID_W-1:0] in_timer_id,
  input  logic [WORD_W-1:0]     in_offset_low,
  input  logic [WORD_W-1:0]     in_offset_high,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_fired_valid,
  input  logic [TIMER_ID_W-1:0] out_fired_id,
  input  logic                  out_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    mismatch_count,
  output int                    events_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [APB_ADDR_W-1:0] BACKOFF_ADDR = APB_ADDR_W'({REG_BACKOFF, 2'b00});

  typedef struct packed {
    logic                  fired_valid;
    logic [TIMER_ID_W-1:0] fired_id;
    logic                  last;
  } timer_event_t;

  timer_event_t          expected_events[$];
  logic [TIME_W-1:0]     now_ticks;
  logic [MAX_TABLE-1:0]  armed;
  logic [TIME_W-1:0]     deadline [MAX_TABLE];
  logic [BACKOFF_W-1:0]  backoff;
  int                    mismatches = 0;
  int                    queued = 0;

  assign mismatch_count = mismatches;
  assign events_pending = queued;

  function automatic void push_event(logic fired, logic [TIMER_ID_W-1:0] id, logic last);
    timer_event_t ev;
    ev.fired_valid = fired;
    ev.fired_id    = id;
    ev.last        = last;
    expected_events.push_back(ev);
  endfunction

  // Work out the results one request causes and update the timer table
  function automatic void predict_timer_events(logic [1:0] req, logic [TIMER_ID_W-1:0] id,
                                               logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi);
    int best;
    int fired;
    timer_event_t tail;
    fired = 0;
    if (req == REQ_SET && id < NUM_TIMERS) begin
      armed[id] = 1'b0;
      // short delay: report at once, leave the timer disarmed
      if (hi == '0 && lo < backoff) begin
        push_event(1'b1, id, 1'b1);
        return;
      end
      deadline[id] = now_ticks + {hi, lo};
      armed[id] = 1'b1;
    end else if (req == REQ_REMOVE && id < NUM_TIMERS) begin
      armed[id] = 1'b0;
    end else if (req == REQ_TICK) begin
      now_ticks = now_ticks + 1'b1;
      // fire due timers, earliest deadline first, lowest id on ties
      forever begin
        best = -1;
        for (int i = 0; i < NUM_TIMERS && i < MAX_TABLE; i++) begin
          if (armed[i] && deadline[i] <= now_ticks &&
              (best < 0 || deadline[i] < deadline[best]))
            best = i;
        end
        if (best < 0) break;
        armed[best] = 1'b0;
        push_event(1'b1, TIMER_ID_W'(best), 1'b0);
        fired++;
      end
      if (fired > 0) begin
        tail = expected_events.pop_back();
        tail.last = 1'b1;
        expected_events.push_back(tail);
        return;
      end
    end
    push_event(1'b0, '0, 1'b1);
  endfunction

  // Compare result transactions, then predict accepted requests and track the register
  always @(posedge clk) begin
    timer_event_t want;
    if (!rst_n) begin
      now_ticks = '0;
      armed     = '0;
      backoff   = BACKOFF_RESET;
      for (int i = 0; i < MAX_TABLE; i++) deadline[i] = '0;
      expected_events.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result fired_valid=%0b fired_id=%0d last=%0b",
                     $realtime, out_fired_valid, out_fired_id, out_last);
        end else begin
          want = expected_events.pop_front();
          if (out_fired_valid !== want.fired_valid || out_fired_id !== want.fired_id ||
              out_last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result mismatch: expected fired_valid=%0b fired_id=%0d last=%0b, got fired_valid=%0b fired_id=%0d last=%0b",
                       $realtime, want.fired_valid, want.fired_id, want.last,
                       out_fired_valid, out_fired_id, out_last);
          end
        end
      end
      if (in_valid && in_ready)
        predict_timer_events(in_req_type, in_timer_id, in_offset_low, in_offset_high);
      if (psel && penable && pwrite && pready && paddr == BACKOFF_ADDR)
        backoff = pwdata[BACKOFF_W-1:0];
    end
    queued = expected_events.size();
  end

endmodule

// ===== test/tb.sv =====
// Testbench top of the virtual timer multiplexer: clock, reset, stimulus and verdict.
module tb;
  import vtm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 500;
  localparam int PHASES = 4;
  localparam int HOLD_CYCLES = 300;
  localparam logic [APB_ADDR_W-1:0] BACKOFF_ADDR = APB_ADDR_W'({REG_BACKOFF, 2'b00});
  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_req_type = REQ_TICK;
  logic [TIMER_ID_W-1:0] in_timer_id = '0;
  logic [WORD_W-1:0]     in_offset_low = '0;
  logic [WORD_W-1:0]     in_offset_high = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic                  out_fired_valid;
  logic [TIMER_ID_W-1:0] out_fired_id;
  logic                  out_last;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic                  tx_idle_en = 1'b1;
  logic                  rx_idle_en = 1'b1;
  logic                  hold_req = 1'b0;
  logic [BACKOFF_W-1:0]  backoff_now = BACKOFF_RESET;
  int                    mismatch_count;
  int                    events_pending;

  always #5 clk = ~clk;

  virtual_timer_multiplexer_unit #(.NUM_TIMERS(NUM_TIMERS_DEF)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_timer_id(in_timer_id), .in_offset_low(in_offset_low),
    .in_offset_high(in_offset_high),
    .out_valid(out_valid), .out_ready(out_ready), .out_fired_valid(out_fired_valid),
    .out_fired_id(out_fired_id), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  vtm_checker #(.NUM_TIMERS(NUM_TIMERS_DEF)) chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_timer_id(in_timer_id), .in_offset_low(in_offset_low),
    .in_offset_high(in_offset_high),
    .out_valid(out_valid), .out_ready(out_ready), .out_fired_valid(out_fired_valid),
    .out_fired_id(out_fired_id), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatch_count(mismatch_count), .events_pending(events_pending)
  );

  // Receiver: one long hold-off on request, otherwise random stall bursts
  always begin
    @(negedge clk);
    if (hold_req) begin
      out_ready = 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_req = 1'b0;
      out_ready = 1'b1;
    end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
      out_ready = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
      out_ready = 1'b1;
    end else begin
      out_ready = 1'b1;
    end
  end

  // Offer one request and hold it until the sequencer accepts it
  task automatic send_req(input logic [1:0] req, input logic [TIMER_ID_W-1:0] id,
                          input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_req_type    = req;
    in_timer_id    = id;
    in_offset_low  = lo;
    in_offset_high = hi;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Register write: setup cycle, then access cycle
  task automatic write_backoff(input logic [BACKOFF_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = BACKOFF_ADDR;
    pwdata  = APB_DATA_W'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    backoff_now = value;
  endtask

  // Wait until every expected result has come back, then let the sequencer settle
  task automatic drain();
    int waited;
    waited = 0;
    in_valid = 1'b0;
    while (events_pending != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
  endtask

  // Random request, weighted toward sets near the backoff and ticks that fire them
  task automatic send_random();
    int pick;
    int kind;
    logic [1:0] req;
    logic [TIMER_ID_W-1:0] id;
    logic [WORD_W-1:0] lo, hi, base;
    pick = $urandom_range(0, 99);
    kind = $urandom_range(0, 9);
    id   = TIMER_ID_W'($urandom_range(0, 15));
    lo   = $urandom;
    hi   = $urandom;
    base = (backoff_now > 8) ? WORD_W'(backoff_now) - 8 : '0;
    if (pick < 40) begin
      req = REQ_TICK;
    end else if (pick < 75) begin
      req = REQ_SET;
      if (kind < 6) begin
        lo = base + WORD_W'($urandom_range(0, 24));
        hi = '0;
      end else if (kind < 8) begin
        lo = WORD_W'($urandom_range(0, 40));
        hi = '0;
      end else if (kind == 8) begin
        // wrapping deadline lands just behind the current time
        lo = ALL_ONES - WORD_W'($urandom_range(0, 10));
        hi = ALL_ONES;
      end else begin
        hi = '0;
      end
    end else if (pick < 88) begin
      req = REQ_REMOVE;
    end else if (pick < 95) begin
      req = REQ_SET;
      if ($urandom_range(0, 1) == 0) hi = '0;
    end else begin
      req = REQ_UNUSED;
    end
    send_req(req, id, lo, hi);
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed: backoff edges, every request code, wrap, ties and re-arm
    send_req(REQ_SET, 4'd0, '0, '0);
    send_req(REQ_SET, 4'd15, 32'd29, '0);
    send_req(REQ_SET, 4'd1, 32'd30, '0);
    send_req(REQ_SET, 4'd2, 32'd30, '0);
    send_req(REQ_SET, 4'd4, '0, 32'd1);
    send_req(REQ_SET, 4'd5, 32'd35, '0);
    send_req(REQ_REMOVE, 4'd5, '0, '0);
    send_req(REQ_REMOVE, 4'd6, ALL_ONES, ALL_ONES);
    send_req(REQ_UNUSED, 4'd9, ALL_ONES, ALL_ONES);
    send_req(REQ_SET, 4'd7, ALL_ONES - 5, ALL_ONES);
    send_req(REQ_SET, 4'd8, ALL_ONES - 2, ALL_ONES);
    send_req(REQ_SET, 4'd9, ALL_ONES - 5, ALL_ONES);
    send_req(REQ_TICK, 4'd0, ALL_ONES, ALL_ONES);
    send_req(REQ_SET, 4'd1, 32'd30, '0);
    send_req(REQ_SET, 4'd3, ALL_ONES, ALL_ONES);
    send_req(REQ_SET, 4'd10, ALL_ONES, '0);
    send_req(REQ_TICK, 4'd15, '0, '0);
    send_req(REQ_SET, 4'd4, '0, '0);
    send_req(REQ_TICK, 4'd0, '0, '0);
    drain();

    // Random phases at several backoff settings; the last one runs without idling
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: write_backoff('0);
        1: write_backoff('1);
        2: write_backoff(16'd16);
        default: write_backoff(BACKOFF_W'($urandom_range(1, 100)));
      endcase
      if (ph == PHASES - 1) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      if (ph == 0) hold_req = 1'b1;
      repeat (RANDOM_ITEMS / PHASES) send_random();
      drain();
    end

    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && events_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #15_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
